### src/plau_pkg.sv
// shared types and constants for the pixel lightness adjust block
// used by the top level, plau_cfg and plau_trip; depends on nothing
`timescale 1ns / 1ps

package plau_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    typedef struct packed {
        logic signed [15:0] lighting_factor;
        logic               rgb_mode;
    } cfg_t;

    // register map
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_FACTOR = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    // hue in degrees with 8 fraction bits
    localparam int HUE_W = 17;
    localparam logic [HUE_W-1:0] DEG60  = 17'd15360;
    localparam logic [HUE_W-1:0] DEG120 = 17'd30720;
    localparam logic [HUE_W-1:0] DEG180 = 17'd46080;
    localparam logic [HUE_W-1:0] DEG240 = 17'd61440;
    localparam logic [HUE_W-1:0] DEG300 = 17'd76800;
    localparam logic [HUE_W-1:0] DEG360 = 17'd92160;

    // 65535 is one in the 16-bit fraction format
    localparam logic [16:0] ONE_FRAC = 17'd65535;

    // channel rebuild divides by 15 * 257; 2^32 - 1 = 3855 * 1114129
    localparam logic [11:0] DIV_3855   = 12'd3855;
    localparam logic [20:0] RECIP_3855 = 21'd1114129;

    // pipelined divider geometry
    localparam int DIV_NUM_W     = 24;
    localparam int DIV_DEN_W     = 8;
    localparam int DIV_Q_W       = 16;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_LAT       = DIV_Q_W / DIV_STEP_BITS;

    // channel rebuild pipeline depth
    localparam int TRIP_LAT = 3;

endpackage

### src/pixel_lightness_adjust_unit.sv
// a pixel taken on start goes via input, s1, divider, a, b, rebuild, output regs; done high
// throughput: one pixel per clock, busy stays low; the divider and rebuild pipelines set depth
// results cannot be held off: done marks each result for exactly one cycle
// reset (rst_n low, async) empties the pipeline, factor = 0, rgb mode = 1
// top level: input stage, rgb and hls front end, dividers, hls rebuild, output register
`timescale 1ns / 1ps

module pixel_lightness_adjust_unit #(
    parameter int FACTOR_FRAC_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  plau_pkg::pixel_in_t              pixel,
    output logic                             done,
    output plau_pkg::pixel_out_t             result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [plau_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import plau_pkg::*;

    localparam int FB      = FACTOR_FRAC_BITS;
    // luminosity adjust sum: lum << FB plus factor * 65535
    localparam int ADJ_W   = (FB + 18 > 34) ? FB + 18 : 34;
    // darken multiplier 2^FB + factor, signed
    localparam int MUL_W   = ((FB > 16) ? FB : 16) + 2;
    localparam int EW      = MUL_W - 1;
    localparam int PW      = EW + 8;
    localparam int SW      = PW + 1;
    localparam int LATENCY = 5 + DIV_LAT + TRIP_LAT;

    localparam logic signed [MUL_W-1:0] ONE_SC  = MUL_W'(1) << FB;
    localparam logic signed [ADJ_W-1:0] LUM_TOP = ADJ_W'(65535) << FB;

    typedef struct packed {
        logic       hls;
        pixel_out_t rgbo;
        logic [15:0] lum;
        logic [HUE_W-1:0] base;
    } side_t;

    typedef struct packed {
        logic       hls;
        logic       gray;
        pixel_out_t rgbo;
        logic [7:0] grayv;
    } tail_t;

    // rgb mode channel: lighten toward 255 or scale toward 0
    function automatic logic [7:0] rgb_chan(input logic [7:0] c,
                                            input logic signed [15:0] f);
        logic signed [MUL_W-1:0] m;
        logic [EW-1:0] e;
        logic [7:0]    a;
        logic [PW-1:0] p;
        logic [PW-1:0] sh;
        logic [SW-1:0] s;
        logic [7:0]    res;
        m = ONE_SC + MUL_W'(f);
        if (f > 0)
        begin
            a = 8'd255 - c;
            e = EW'($unsigned(f));
        end
        else
        begin
            a = c;
            e = (m > 0) ? EW'($unsigned(m)) : '0;
        end
        p  = PW'(a) * PW'(e);
        sh = p >> FB;
        if (f > 0)
        begin
            s   = SW'(c) + SW'(sh);
            res = (s > SW'(255)) ? 8'd255 : s[7:0];
        end
        else
            res = (sh > PW'(255)) ? 8'd255 : sh[7:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    cfg_t cfg;

    plau_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the pipeline never stalls, so a start is always taken
    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // ---------------------------------------------------------------
    // stage 0: input register, config captured with the pixel
    // ---------------------------------------------------------------
    logic      s0_valid_reg;
    pixel_in_t s0_pix_reg;
    cfg_t      s0_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pix_reg <= pixel;
            s0_cfg_reg <= cfg;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: rgb path, max/min, luminosity and its adjustment,
    // divider operands for saturation and hue
    // ---------------------------------------------------------------
    logic [7:0]  r, g, b, mx, mn, dd;
    logic [8:0]  sum, den9;
    logic [7:0]  den;
    logic [15:0] lum;
    logic signed [ADJ_W-1:0] lum_sh, f_ext, adj_sum, adj_shift;
    logic [15:0] lum_adj;
    logic [9:0]  y10;
    logic [8:0]  y;
    logic [12:0] y15;
    logic [HUE_W-1:0] base;
    logic signed [15:0] f;
    side_t       s1_side_next;
    logic [DIV_NUM_W-1:0] sat_num_next, hue_num_next;

    assign r = s0_pix_reg.red_in;
    assign g = s0_pix_reg.green_in;
    assign b = s0_pix_reg.blue_in;
    assign f = s0_cfg_reg.lighting_factor;

    always_comb
    begin
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
    end

    assign dd   = mx - mn;
    assign sum  = 9'(mx) + 9'(mn);
    // sum * 65535 / 510 is exactly 128 * sum + sum / 2
    assign lum  = 16'({sum, 7'b0}) + 16'(sum[8:1]);
    assign den9 = 9'd510 - sum;
    // gray pixel: nonzero divisor so saturation comes out zero for black and white too
    assign den  = (dd == 8'd0) ? 8'd1 : ((sum < 9'd255) ? sum[7:0] : den9[7:0]);

    // luminosity plus factor, saturated to the unit interval
    always_comb
    begin
        lum_sh    = ADJ_W'(lum) << FB;
        f_ext     = ADJ_W'(f);
        adj_sum   = lum_sh + (f_ext <<< 16) - f_ext;
        adj_shift = adj_sum >>> FB;
        if (adj_sum <= 0)
            lum_adj = 16'd0;
        else if (adj_sum >= LUM_TOP)
            lum_adj = 16'hFFFF;
        else
            lum_adj = adj_shift[15:0];
    end

    // hue sector: red wins ties, then green; numerator offset by one sector
    always_comb
    begin
        if (r == mx)
        begin
            y10  = 10'(dd) + 10'(g) - 10'(b);
            base = DEG300;
        end
        else if (g == mx)
        begin
            y10  = 10'(dd) + 10'(b) - 10'(r);
            base = DEG60;
        end
        else
        begin
            y10  = 10'(dd) + 10'(r) - 10'(g);
            base = DEG180;
        end
    end

    assign y            = y10[8:0];
    assign y15          = 13'({y, 4'b0}) - 13'(y);
    assign hue_num_next = DIV_NUM_W'({y15, 10'b0});
    assign sat_num_next = DIV_NUM_W'({dd, 16'b0}) - DIV_NUM_W'(dd);

    always_comb
    begin
        s1_side_next.hls  = (f != 16'sd0) && !s0_cfg_reg.rgb_mode;
        s1_side_next.lum  = lum_adj;
        s1_side_next.base = base;
        if (f == 16'sd0)
        begin
            s1_side_next.rgbo.red_out   = r;
            s1_side_next.rgbo.green_out = g;
            s1_side_next.rgbo.blue_out  = b;
        end
        else
        begin
            s1_side_next.rgbo.red_out   = rgb_chan(r, f);
            s1_side_next.rgbo.green_out = rgb_chan(g, f);
            s1_side_next.rgbo.blue_out  = rgb_chan(b, f);
        end
    end

    logic                 s1_valid_reg;
    side_t                s1_side_reg;
    logic [DIV_NUM_W-1:0] s1_sat_num_reg, s1_hue_num_reg;
    logic [DIV_DEN_W-1:0] s1_den_reg, s1_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg    <= s1_side_next;
        s1_sat_num_reg <= sat_num_next;
        s1_hue_num_reg <= hue_num_next;
        s1_den_reg     <= den;
        s1_d_reg       <= dd;
    end

    // ---------------------------------------------------------------
    // dividers: saturation and hue fraction, side data delayed alongside
    // ---------------------------------------------------------------
    logic [DIV_Q_W-1:0] sat_q, hue_q;

    plau_div #(
        .NUM_W     (DIV_NUM_W),
        .DEN_W     (DIV_DEN_W),
        .Q_W       (DIV_Q_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_div_sat (
        .clk (clk),
        .num (s1_sat_num_reg),
        .den (s1_den_reg),
        .quo (sat_q)
    );

    plau_div #(
        .NUM_W     (DIV_NUM_W),
        .DEN_W     (DIV_DEN_W),
        .Q_W       (DIV_Q_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_div_hue (
        .clk (clk),
        .num (s1_hue_num_reg),
        .den (s1_d_reg),
        .quo (hue_q)
    );

    logic  dv_valid_reg [DIV_LAT];
    side_t dv_side_reg  [DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                dv_valid_reg[i] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= s1_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
                dv_valid_reg[i] <= dv_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_side_reg[0] <= s1_side_reg;
        for (int i = 1; i < DIV_LAT; i++)
            dv_side_reg[i] <= dv_side_reg[i-1];
    end

    // ---------------------------------------------------------------
    // stage a: hue assembly, luminosity times saturation
    // ---------------------------------------------------------------
    side_t            da;
    logic [HUE_W-1:0] hue_raw, hue_next;
    logic [31:0]      prod_next;

    assign da        = dv_side_reg[DIV_LAT-1];
    assign hue_raw   = da.base + HUE_W'(hue_q);
    assign hue_next  = (hue_raw > DEG360) ? hue_raw - DEG360 : hue_raw;
    assign prod_next = 32'(da.lum) * 32'(sat_q);

    logic             a_valid_reg;
    logic             a_hls_reg;
    pixel_out_t       a_rgbo_reg;
    logic [15:0]      a_lum_reg, a_sat_reg;
    logic [HUE_W-1:0] a_hue_reg;
    logic [31:0]      a_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= dv_valid_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        a_hls_reg  <= da.hls;
        a_rgbo_reg <= da.rgbo;
        a_lum_reg  <= da.lum;
        a_sat_reg  <= sat_q;
        a_hue_reg  <= hue_next;
        a_prod_reg <= prod_next;
    end

    // ---------------------------------------------------------------
    // stage b: temp levels t1/t2, gray level, three channel hues
    // ---------------------------------------------------------------
    logic [15:0] pq0;
    logic [16:0] prem, prem_f, pfl, pce, t2_full;
    logic        pge;
    logic [17:0] t1_diff;
    logic [15:0] t1_next, t2_next;
    logic [7:0]  gq0, grayv_next;
    logic [HUE_W-1:0] h_r_raw, h_r_next, h_b_next;

    // lum * sat / 65535: high half plus low half, one correction
    assign pq0    = a_prod_reg[31:16];
    assign prem   = 17'(pq0) + 17'(a_prod_reg[15:0]);
    assign pge    = (prem >= ONE_FRAC);
    assign pfl    = 17'(pq0) + (pge ? 17'd1 : 17'd0);
    assign prem_f = pge ? prem - ONE_FRAC : prem;
    assign pce    = pfl + ((prem_f != 17'd0) ? 17'd1 : 17'd0);

    assign t2_full = (a_lum_reg < 16'd32768)
                   ? 17'(a_lum_reg) + pfl
                   : 17'(a_lum_reg) + 17'(a_sat_reg) - pce;
    assign t2_next = t2_full[15:0];
    assign t1_diff = 18'({a_lum_reg, 1'b0}) - 18'(t2_next);
    assign t1_next = t1_diff[17] ? 16'd0 : t1_diff[15:0];

    // gray level lum / 257: estimate lum >> 8, back off once if too big
    assign gq0 = a_lum_reg[15:8];
    assign grayv_next = (17'({gq0, 8'b0}) + 17'(gq0) > 17'(a_lum_reg)) ? gq0 - 8'd1 : gq0;

    assign h_r_raw  = a_hue_reg + DEG120;
    assign h_r_next = (h_r_raw > DEG360) ? h_r_raw - DEG360 : h_r_raw;
    assign h_b_next = (a_hue_reg < DEG120) ? a_hue_reg + DEG240 : a_hue_reg - DEG120;

    logic             b_valid_reg;
    tail_t            b_tail_reg;
    logic [15:0]      b_t1_reg, b_t2_reg;
    logic [HUE_W-1:0] b_hr_reg, b_hg_reg, b_hb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_tail_reg.hls   <= a_hls_reg;
        b_tail_reg.gray  <= (a_sat_reg == 16'd0);
        b_tail_reg.rgbo  <= a_rgbo_reg;
        b_tail_reg.grayv <= grayv_next;
        b_t1_reg         <= t1_next;
        b_t2_reg         <= t2_next;
        b_hr_reg         <= h_r_next;
        b_hg_reg         <= a_hue_reg;
        b_hb_reg         <= h_b_next;
    end

    // ---------------------------------------------------------------
    // channel rebuild, one unit per channel
    // ---------------------------------------------------------------
    logic [7:0] lvl_r, lvl_g, lvl_b;

    plau_trip u_trip_r (.clk(clk), .t1(b_t1_reg), .t2(b_t2_reg), .hue(b_hr_reg),
                        .level(lvl_r));
    plau_trip u_trip_g (.clk(clk), .t1(b_t1_reg), .t2(b_t2_reg), .hue(b_hg_reg),
                        .level(lvl_g));
    plau_trip u_trip_b (.clk(clk), .t1(b_t1_reg), .t2(b_t2_reg), .hue(b_hb_reg),
                        .level(lvl_b));

    logic  tr_valid_reg [TRIP_LAT];
    tail_t tr_tail_reg  [TRIP_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TRIP_LAT; i++)
                tr_valid_reg[i] <= 1'b0;
        end
        else
        begin
            tr_valid_reg[0] <= b_valid_reg;
            for (int i = 1; i < TRIP_LAT; i++)
                tr_valid_reg[i] <= tr_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tr_tail_reg[0] <= b_tail_reg;
        for (int i = 1; i < TRIP_LAT; i++)
            tr_tail_reg[i] <= tr_tail_reg[i-1];
    end

    // ---------------------------------------------------------------
    // output register: pick rgb/pass-through, gray or rebuilt channels
    // ---------------------------------------------------------------
    tail_t      tt;
    pixel_out_t result_next;
    pixel_out_t result_reg;
    logic       done_reg;

    assign tt = tr_tail_reg[TRIP_LAT-1];

    always_comb
    begin
        if (!tt.hls)
            result_next = tt.rgbo;
        else if (tt.gray)
        begin
            result_next.red_out   = tt.grayv;
            result_next.green_out = tt.grayv;
            result_next.blue_out  = tt.grayv;
        end
        else
        begin
            result_next.red_out   = lvl_r;
            result_next.green_out = lvl_g;
            result_next.blue_out  = lvl_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tr_valid_reg[TRIP_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // every result traces back to a transfer a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching input transfer");

    // rebuilt temp levels are ordered for a colored pixel
    a_temp_order: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_tail_reg.hls && !b_tail_reg.gray) |-> (b_t2_reg >= b_t1_reg))
        else $error("t2 below t1 in hls rebuild");

    // a gray pixel in hls mode leaves as gray
    a_gray_out: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(tr_valid_reg[TRIP_LAT-1] && tt.hls && tt.gray) && done) |->
        (result.red_out == result.green_out && result.green_out == result.blue_out))
        else $error("gray pixel came out colored");

endmodule

### src/plau_cfg.sv
// apb register file: lighting factor and mode
// depends on plau_pkg
`timescale 1ns / 1ps

module plau_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [plau_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output plau_pkg::cfg_t                   cfg
);
    import plau_pkg::*;

    logic signed [15:0] factor_reg, factor_next;
    logic               mode_reg, mode_next;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[CFG_ADDR_W-1];

    always_comb
    begin
        factor_next = factor_reg;
        mode_next   = mode_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_FACTOR: factor_next = $signed(pwdata[15:0]);
                REG_MODE:   mode_next   = pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FACTOR: prdata = {{16{factor_reg[15]}}, factor_reg};
            REG_MODE:   prdata = {31'd0, mode_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= '0;
            mode_reg   <= 1'b1;
        end
        else
        begin
            factor_reg <= factor_next;
            mode_reg   <= mode_next;
        end
    end

    assign cfg.lighting_factor = factor_reg;
    assign cfg.rgb_mode        = mode_reg;

endmodule

### src/plau_div.sv
// pipelined restoring divider, STEP_BITS quotient bits per stage
// no dependencies; quotient must fit in Q_W bits
`timescale 1ns / 1ps

module plau_div #(
    parameter int NUM_W     = 24,
    parameter int DEN_W     = 8,
    parameter int Q_W       = 16,
    parameter int STEP_BITS = 4
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);
    localparam int STAGES = Q_W / STEP_BITS;

    logic [NUM_W-1:0] rem_reg [STAGES];
    logic [Q_W-1:0]   q_reg   [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [NUM_W-1:0] rem_in, rem_next;
        logic [Q_W-1:0]   q_in, q_next;
        logic [DEN_W-1:0] den_in;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign q_in   = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        always_comb
        begin
            logic [NUM_W-1:0] trial;
            rem_next = rem_in;
            q_next   = q_in;
            for (int k = 0; k < STEP_BITS; k++)
            begin
                trial = NUM_W'(den_in) << (Q_W - 1 - s * STEP_BITS - k);
                if (trial <= rem_next)
                begin
                    rem_next = rem_next - trial;
                    q_next[Q_W - 1 - s * STEP_BITS - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            q_reg[s]   <= q_next;
            den_reg[s] <= den_in;
        end
    end

    assign quo = q_reg[STAGES-1];

endmodule

### src/plau_trip.sv
// one channel of the hls rebuild: hue weight, blend, scale to 8 bits
// depends on plau_pkg; three register stages
`timescale 1ns / 1ps

module plau_trip (
    input  logic                        clk,
    input  logic [15:0]                 t1,
    input  logic [15:0]                 t2,
    input  logic [plau_pkg::HUE_W-1:0]  hue,
    output logic [7:0]                  level
);
    import plau_pkg::*;

    logic [HUE_W-1:0] w_full;
    logic [13:0]      w;
    logic [29:0]      num_next, num_reg;
    logic [19:0]      z;
    logic [40:0]      prod_next, prod_reg;
    logic [19:0]      z_reg;
    logic [8:0]       q0;
    logic [20:0]      rem;
    logic [9:0]       q;
    logic [7:0]       level_next, level_reg;

    // piecewise hue weight
    always_comb
    begin
        if (hue < DEG60)
            w_full = hue;
        else if (hue < DEG180)
            w_full = DEG60;
        else if (hue < DEG240)
            w_full = DEG240 - hue;
        else
            w_full = '0;
        w = w_full[13:0];
    end

    assign num_next = 30'(t1) * 30'(DEG60) + 30'(t2 - t1) * 30'(w);

    // divide by 15360 * 257: drop 10 bits, then reciprocal of 3855
    assign z         = num_reg[29:10];
    assign prod_next = 41'(z) * 41'(RECIP_3855);

    assign q0  = prod_reg[40:32];
    assign rem = 21'(z_reg) - 21'(q0) * 21'(DIV_3855);
    assign q   = 10'(q0) + ((rem >= 21'(DIV_3855)) ? 10'd1 : 10'd0);
    assign level_next = (q > 10'd255) ? 8'd255 : q[7:0];

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        prod_reg  <= prod_next;
        z_reg     <= z;
        level_reg <= level_next;
    end

    assign level = level_reg;

endmodule
